// ----- sv/bdjv_pkg.sv -----
// ----------------------------------------------------------------------------
// bdjv_pkg
// Item types, command codes and fixed widths of the descriptor vote block.
// ----------------------------------------------------------------------------
package bdjv_pkg;

	localparam int WORD_W    = 18;   // width of one descriptor word
	localparam int IMG_W     = 8;    // width of an image index
	localparam int POP_W     = 5;    // popcount of one word, up to 18
	localparam int SUM_W     = 15;   // saturating intersect and union sums
	localparam int SIM_W     = 16;   // Q0.16 similarity
	localparam int SCORE_W   = 40;   // Q24.16 image score
	localparam int DEN_W     = 19;   // 10 * union + 1
	localparam int DIV_STEPS = SIM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [1:0] CMD_COMPARE = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [WORD_W-1:0] ref_word;
		logic [WORD_W-1:0] query_word;
		logic [IMG_W-1:0]  image_index;
		logic              last_word;
	} req_item_t;

	typedef struct packed {
		logic [SIM_W-1:0]   similarity;
		logic               above_threshold;
		logic [IMG_W-1:0]   result_image;
		logic [SCORE_W-1:0] image_score;
		logic               is_readout;
	} rsp_item_t;

	function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] w);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			n = n + POP_W'(w[i]);
		end
		return n;
	endfunction

endpackage

// ----- sv/binary_descriptor_jaccard_vote.sv -----
// ----------------------------------------------------------------------------
// binary_descriptor_jaccard_vote
// Jaccard similarity of binary descriptors with per-image score voting.
// ----------------------------------------------------------------------------
// The req channel carries one command item: a compare of one reference and
// query word pair, a score read, or a clear of all scores. The rsp channel
// returns one item for the last word of a compare and for every read.
// Both channels use valid/stall; an item moves on a clock edge with valid
// high and stall low.
// A compare word that is not the last is summed as it is accepted. The
// last word then passes through a setup state for the divide, the divide
// state of the shared restoring divider that produces one quotient bit a
// cycle, and a finish state that updates the score memory and loads the
// output register. A read passes through a wait state for the registered
// read port of the score memory, then the finish state. A clear zeroes
// every memory entry, one per cycle. After reset the block runs the same
// clearing pass with req_stall high. The result sits in an output register,
// so the next item is accepted while it waits; a finished result that finds
// the output register still full and rsp_stall high is held until it drains.
// ----------------------------------------------------------------------------
module binary_descriptor_jaccard_vote #(
	parameter int IMG_DEPTH = 256,
	parameter int WORD_BITS = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  bdjv_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output bdjv_pkg::rsp_item_t  rsp
);
	import bdjv_pkg::*;

	localparam int AW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam logic [WORD_W-1:0] WMASK = {WORD_W{1'b1}} >> (WORD_W - WORD_BITS);
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_RDW   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_CLR   = 3'd5;

	logic [2:0]         state_q;
	logic [SUM_W-1:0]   isum_q, usum_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [CNT_W-1:0]   div_cnt_q;
	logic               rsp_valid_q;
	rsp_item_t          rsp_q;

	logic [1:0]         cmd_q;
	logic [IMG_W-1:0]   img_q;
	logic [AW-1:0]      addr_q;
	logic               img_ok_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [SIM_W-1:0]   quo_q;
	logic               above_q;
	logic [SCORE_W-1:0] rd_q;

	logic [SCORE_W-1:0] score_mem [IMG_DEPTH];

	logic               req_fire, fin_fire;
	logic [WORD_W-1:0]  rw, qw;
	logic [SUM_W:0]     isum_add, usum_add;
	logic [SUM_W-1:0]   isum_next, usum_next;
	logic [DEN_W-1:0]   den_calc, num_calc;
	logic [DEN_W+1:0]   i50;
	logic [DEN_W:0]     trial;
	logic               trial_ge;
	logic [SCORE_W:0]   score_add;
	logic [SCORE_W-1:0] score_new;
	logic               add_score;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [SCORE_W-1:0] mem_wdata;
	rsp_item_t          rsp_next;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign fin_fire  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// Word popcounts and saturating sums.
	assign rw        = req.ref_word & WMASK;
	assign qw        = req.query_word & WMASK;
	assign isum_add  = {1'b0, isum_q} + (SUM_W+1)'(popcount(rw & qw));
	assign usum_add  = {1'b0, usum_q} + (SUM_W+1)'(popcount(rw | qw));
	assign isum_next = isum_add[SUM_W] ? SUM_MAX : isum_add[SUM_W-1:0];
	assign usum_next = usum_add[SUM_W] ? SUM_MAX : usum_add[SUM_W-1:0];

	// The dividend is 10*I shifted left by 16, so the partial remainder starts
	// at 10*I and only zeros are shifted in. I <= U keeps the quotient in 16 bits.
	assign den_calc = (DEN_W'(usum_q) << 3) + (DEN_W'(usum_q) << 1) + DEN_W'(1);
	assign num_calc = (DEN_W'(isum_q) << 3) + (DEN_W'(isum_q) << 1);
	assign i50      = ((DEN_W+2)'(isum_q) << 5) + ((DEN_W+2)'(isum_q) << 4)
	                + ((DEN_W+2)'(isum_q) << 1);

	assign trial    = {rem_q, 1'b0};
	assign trial_ge = trial >= {1'b0, den_q};

	assign add_score = (cmd_q == CMD_COMPARE) && img_ok_q && above_q;
	assign score_add = {1'b0, rd_q} + (SCORE_W+1)'(quo_q);
	assign score_new = score_add[SCORE_W] ? SCORE_MAX : score_add[SCORE_W-1:0];

	always_comb begin
		rsp_next = '0;
		rsp_next.result_image = img_q;
		if (cmd_q == CMD_READ) begin
			rsp_next.is_readout  = 1'b1;
			rsp_next.image_score = img_ok_q ? rd_q : '0;
		end else begin
			rsp_next.similarity      = quo_q;
			rsp_next.above_threshold = add_score;
			rsp_next.image_score     = !img_ok_q ? '0 : (add_score ? score_new : rd_q);
		end
	end

	assign mem_we    = (state_q == ST_CLR) || (fin_fire && add_score);
	assign mem_waddr = (state_q == ST_CLR) ? clr_cnt_q : addr_q;
	assign mem_wdata = (state_q == ST_CLR) ? '0 : score_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			isum_q      <= '0;
			usum_q      <= '0;
			clr_cnt_q   <= '0;
			div_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A new result may load in the same cycle as the old one drains.
			if (fin_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.cmd)
							CMD_COMPARE: begin
								isum_q <= isum_next;
								usum_q <= usum_next;
								if (req.last_word) begin
									state_q <= ST_SETUP;
								end
							end
							CMD_READ: begin
								state_q <= ST_RDW;
							end
							CMD_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= ST_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SETUP: begin
					isum_q    <= '0;
					usum_q    <= '0;
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + CNT_W'(1);
					if (div_cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_RDW: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(IMG_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q    <= req.cmd;
			img_q    <= req.image_index;
			addr_q   <= AW'(req.image_index);
			img_ok_q <= 32'(req.image_index) < IMG_DEPTH;
		end
		if (state_q == ST_SETUP) begin
			den_q   <= den_calc;
			rem_q   <= num_calc;
			above_q <= i50 > (DEN_W+2)'(den_calc);
		end
		if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[SIM_W-2:0], trial_ge};
		end
		if (fin_fire) begin
			rsp_q <= rsp_next;
		end
	end

	// Score memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			score_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= score_mem[addr_q];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.cmd == CMD_COMPARE && req.last_word)
		|-> ##2 (isum_q == '0 && usum_q == '0))
		else $error("sums not cleared after the last word of a pair");

	a_isum_le_usum: assert property (@(posedge clk) disable iff (!arst_n)
		isum_q <= usum_q)
		else $error("intersect sum exceeds union sum");

	a_above_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.is_readout && rsp.above_threshold) |-> (rsp.similarity != '0))
		else $error("score added with zero similarity");

	a_readout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.is_readout) |-> (rsp.similarity == '0 && !rsp.above_threshold))
		else $error("read result carries compare fields");

endmodule

// ----- sim/tb_binary_descriptor_jaccard_vote.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_descriptor_jaccard_vote
// Self-checking bench for the descriptor Jaccard vote block.
// ----------------------------------------------------------------------------
// Word pairs, score reads and score clears go in on the req channel. A local
// model of the sums and the per-image score table works out each result as
// the item is accepted, and the rsp channel is checked field by field against
// the oldest outstanding result. Directed cases cover the empty union, the
// threshold edge and the unused command. Random descriptors of varied length
// and similarity follow, with random gaps and stalls on both channels, then
// a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_binary_descriptor_jaccard_vote;
	import bdjv_pkg::*;

	localparam int NUM_IMG     = 256;
	localparam int QUIET_LIMIT = 4000;   // a clear plus the longest bursts, several times over
	localparam int END_SETTLE  = 300;    // covers a full clear of the score memory
	localparam int PRINT_CAP   = 100;

	localparam logic [1:0]         CMD_UNUSED = 2'd3;
	localparam logic [SUM_W-1:0]   SUM_CAP    = '1;
	localparam logic [SCORE_W-1:0] SCORE_CAP  = '1;
	localparam logic [WORD_W-1:0]  ALL_ONES   = '1;

	typedef enum {QUERY_RANDOM, QUERY_NEAR, QUERY_SUBSET, QUERY_EXTREME} query_style_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	// Local copy of the block state.
	logic [SUM_W-1:0]   isect_acc = '0;
	logic [SUM_W-1:0]   union_acc = '0;
	logic [SCORE_W-1:0] vote_score [NUM_IMG];

	rsp_item_t awaited_scores [$];
	int        mismatch_count = 0;
	int        sent_items     = 0;
	int        quiet_cycles   = 0;
	int        stall_left     = 0;
	bit        idle_on        = 1'b1;

	binary_descriptor_jaccard_vote dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
		input int unsigned add);
		int unsigned t;
		t = acc + add;
		return (t > SUM_CAP) ? SUM_CAP : SUM_W'(t);
	endfunction

	// Applies one accepted item to the local state and queues its result, if any.
	function automatic void predict_vote(input req_item_t it);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quot;
		logic [63:0] total;
		logic        hit;
		bit          known_img;
		rsp_item_t   want;
		want      = '0;
		known_img = int'(it.image_index) < NUM_IMG;
		case (it.cmd)
		CMD_COMPARE: begin
			isect_acc = sat_sum(isect_acc, $countones(it.ref_word & it.query_word));
			union_acc = sat_sum(union_acc, $countones(it.ref_word | it.query_word));
			if (it.last_word) begin
				num  = 64'(isect_acc) * 64'd655360;
				den  = 64'(union_acc) * 64'd10 + 64'd1;
				quot = num / den;
				hit  = (64'(isect_acc) * 64'd50) > den;
				if (known_img) begin
					if (hit) begin
						total = 64'(vote_score[it.image_index]) + 64'(quot[SIM_W-1:0]);
						vote_score[it.image_index] = (total > 64'(SCORE_CAP)) ?
							SCORE_CAP : total[SCORE_W-1:0];
					end
					want.image_score = vote_score[it.image_index];
				end else begin
					hit = 1'b0;
				end
				want.similarity      = quot[SIM_W-1:0];
				want.above_threshold = hit;
				want.result_image    = it.image_index;
				want.is_readout      = 1'b0;
				isect_acc = '0;
				union_acc = '0;
				awaited_scores.insert(awaited_scores.size(), want);
			end
		end
		CMD_READ: begin
			want.result_image = it.image_index;
			want.image_score  = known_img ? vote_score[it.image_index] : '0;
			want.is_readout   = 1'b1;
			awaited_scores.insert(awaited_scores.size(), want);
		end
		CMD_CLEAR: begin
			foreach (vote_score[i]) vote_score[i] = '0;
		end
		default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
	endtask

	function automatic req_item_t make_item(input logic [1:0] cmd,
		input logic [WORD_W-1:0] rw, input logic [WORD_W-1:0] qw,
		input logic [IMG_W-1:0] img, input logic last);
		req_item_t it;
		it.cmd         = cmd;
		it.ref_word    = rw;
		it.query_word  = qw;
		it.image_index = img;
		it.last_word   = last;
		return it;
	endfunction

	function automatic logic [IMG_W-1:0] pick_image();
		// Mostly a few hot images so that scores build up and reads hit them.
		return ($urandom_range(0, 3) == 0) ? IMG_W'($urandom_range(0, NUM_IMG - 1)) :
			IMG_W'($urandom_range(0, 7));
	endfunction

	// Presents one item and returns at the edge where it is accepted, with
	// valid still high so that a following item can go out without a gap.
	task automatic send_item(input req_item_t it);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		predict_vote(it);
		if (it.cmd != CMD_UNUSED)
			sent_items++;
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_scores.size() != 0);
	endtask

	task automatic send_descriptor(input logic [IMG_W-1:0] img, input int words);
		logic [WORD_W-1:0] rw;
		logic [WORD_W-1:0] qw;
		query_style_t      style;
		style = query_style_t'($urandom_range(0, 3));
		for (int k = 0; k < words; k++) begin
			rw = WORD_W'($urandom);
			case (style)
			QUERY_RANDOM: begin
				qw = WORD_W'($urandom);
			end
			QUERY_NEAR: begin
				qw = rw ^ WORD_W'($urandom & $urandom & $urandom);
			end
			QUERY_SUBSET: begin
				qw = rw & WORD_W'($urandom);
			end
			default: begin
				rw = $urandom_range(0, 1) ? ALL_ONES : '0;
				qw = $urandom_range(0, 1) ? ALL_ONES : '0;
			end
			endcase
			// A read in the middle of a descriptor must leave the sums alone.
			if ($urandom_range(0, 9) == 0)
				send_item(make_item(CMD_READ, WORD_W'($urandom), WORD_W'($urandom),
					pick_image(), 1'($urandom)));
			send_item(make_item(CMD_COMPARE, rw, qw, img, k == words - 1));
		end
	endtask

	task automatic test_directed_cases();
		send_item(make_item(CMD_READ, '0, '0, 8'd0, 1'b0));
		// Empty union gives a zero similarity.
		send_item(make_item(CMD_COMPARE, '0, '0, 8'd0, 1'b1));
		send_item(make_item(CMD_COMPARE, ALL_ONES, ALL_ONES, 8'd255, 1'b1));
		send_item(make_item(CMD_COMPARE, ALL_ONES, '0, 8'd1, 1'b0));
		send_item(make_item(CMD_COMPARE, '0, '0, 8'd1, 1'b1));
		// One shared bit out of five sits just under the threshold, out of four above it.
		send_item(make_item(CMD_COMPARE, 18'h0001F, 18'h00001, 8'd2, 1'b1));
		send_item(make_item(CMD_COMPARE, 18'h0000F, 18'h00001, 8'd2, 1'b1));
		send_item(make_item(CMD_COMPARE, 18'h2AAAA, 18'h15555, 8'd3, 1'b0));
		send_item(make_item(CMD_READ, ALL_ONES, ALL_ONES, 8'd255, 1'b1));
		send_item(make_item(CMD_COMPARE, ALL_ONES, ALL_ONES, 8'd3, 1'b0));
		send_item(make_item(CMD_COMPARE, 18'h00001, 18'h20000, 8'd3, 1'b1));
		send_item(make_item(CMD_READ, '0, '0, 8'd2, 1'b0));
		send_item(make_item(CMD_UNUSED, ALL_ONES, ALL_ONES, 8'd255, 1'b1));
		send_item(make_item(CMD_COMPARE, ALL_ONES, 18'h3FFF0, 8'd255, 1'b1));
		send_item(make_item(CMD_READ, '0, '0, 8'd255, 1'b0));
		send_item(make_item(CMD_CLEAR, ALL_ONES, ALL_ONES, 8'd255, 1'b1));
		send_item(make_item(CMD_READ, '0, '0, 8'd255, 1'b0));
		send_item(make_item(CMD_READ, '0, '0, 8'd3, 1'b1));
		send_item(make_item(CMD_COMPARE, 18'h3C3C3, 18'h3C0C3, 8'd255, 1'b1));
		send_item(make_item(CMD_CLEAR, '0, '0, 8'd0, 1'b0));
		send_item(make_item(CMD_READ, '0, '0, 8'd255, 1'b0));
	endtask

	task automatic test_random_votes(input int count);
		int stop_at;
		int pick;
		stop_at = sent_items + count;
		while (sent_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				send_descriptor(pick_image(), ($urandom_range(0, 9) == 0) ?
					$urandom_range(13, 40) : $urandom_range(1, 12));
			else if (pick < 91)
				send_item(make_item(CMD_READ, WORD_W'($urandom), WORD_W'($urandom),
					pick_image(), 1'($urandom)));
			else if (pick < 95)
				send_item(make_item(CMD_UNUSED, WORD_W'($urandom), WORD_W'($urandom),
					IMG_W'($urandom), 1'($urandom)));
			else if (pick < 97)
				send_item(make_item(CMD_CLEAR, WORD_W'($urandom), WORD_W'($urandom),
					IMG_W'($urandom), 1'($urandom)));
			else
				wait_for_results();
		end
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		test_random_votes(200);
	endtask

	// Receiver side: random stall bursts while idling is enabled.
	always @(posedge clk) begin
		if (!idle_on)
			stall_left = 0;
		else if (stall_left != 0)
			stall_left--;
		else if ($urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 17);
		rsp_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_scores.size() == 0) begin
				report_mismatch("unexpected result for image", 64'(rsp.result_image), '0);
			end else begin
				want = awaited_scores.pop_front();
				if (rsp.similarity !== want.similarity)
					report_mismatch("similarity", 64'(rsp.similarity), 64'(want.similarity));
				if (rsp.above_threshold !== want.above_threshold)
					report_mismatch("above_threshold", 64'(rsp.above_threshold),
						64'(want.above_threshold));
				if (rsp.result_image !== want.result_image)
					report_mismatch("result_image", 64'(rsp.result_image),
						64'(want.result_image));
				if (rsp.image_score !== want.image_score)
					report_mismatch("image_score", 64'(rsp.image_score), 64'(want.image_score));
				if (rsp.is_readout !== want.is_readout)
					report_mismatch("is_readout", 64'(rsp.is_readout), 64'(want.is_readout));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		foreach (vote_score[i]) vote_score[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_votes(600);
		// Let everything drain before the full-rate stretch.
		wait_for_results();
		test_full_rate();
		wait_for_results();
		repeat (END_SETTLE) @(posedge clk);
		if (awaited_scores.size() != 0)
			report_mismatch("results never returned", 64'(awaited_scores.size()), '0);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- binary_descriptor_jaccard_vote.f -----
sv/bdjv_pkg.sv
sv/binary_descriptor_jaccard_vote.sv
sim/tb_binary_descriptor_jaccard_vote.sv
